FILE: design/rao_pkg.sv
// Shared types and constants for the router advertisement option parser.
package rao_pkg;

  localparam logic [11:0] HDR_BYTES        = 12'd16;
  localparam logic [11:0] OPT_UNIT         = 12'd8;
  localparam logic [7:0]  PREFIX_OPT_TYPE  = 8'd3;
  localparam logic [10:0] PREFIX_OPT_BYTES = 11'd32;
  localparam logic [11:0] MANAGED_POS      = 12'd5;
  localparam int          MANAGED_BIT      = 7;
  localparam logic [11:0] POS_MAX          = 12'd4095;
  localparam logic [6:0]  COUNT_MAX        = 7'd127;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_SHORT,
    ST_MANAGED,
    ST_OVERRUN,
    ST_BAD_PREFIX_LEN,
    ST_ZERO_LEN
  } rao_status_t;

  typedef struct packed {
    logic        kind;
    rao_status_t status;
    logic [63:0] prefix_upper;
    logic [63:0] prefix_lower;
    logic [7:0]  prefix_bits;
    logic [7:0]  prefix_flags;
    logic [31:0] valid_lifetime;
    logic [31:0] preferred_lifetime;
    logic [6:0]  record_count;
    logic        last;
  } rao_result_t;

  // up to two results enter the output queue per input beat
  typedef struct packed {
    logic first;
    logic second;
  } rao_push_t;

endpackage

FILE: design/rao_out_fifo.sv
// Small output queue that takes up to two results per cycle and releases one per cycle while out_ready is high.
module rao_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  rao_pkg::rao_push_t   push,
  input  rao_pkg::rao_result_t entry_first,
  input  rao_pkg::rao_result_t entry_second,
  output logic                 room_for_two,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rao_pkg::rao_result_t out_entry
);

  rao_pkg::rao_result_t            mem [rao_pkg::FIFO_DEPTH];
  logic [rao_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [rao_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [rao_pkg::FIFO_CNT_W-1:0]  count;
  logic [rao_pkg::FIFO_CNT_W-1:0]  push_cnt;
  logic                            pop;

  assign out_valid    = (count != '0);
  assign out_entry    = mem[rd_ptr];
  assign pop          = out_valid && out_ready;
  assign room_for_two = (count <= rao_pkg::FIFO_CNT_W'(rao_pkg::FIFO_DEPTH - 2));
  assign push_cnt     = rao_pkg::FIFO_CNT_W'(push.first) + rao_pkg::FIFO_CNT_W'(push.second);

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= entry_first;
    end
    if (push.second) begin
      mem[wr_ptr + rao_pkg::FIFO_PTR_W'(1)] <= entry_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[rao_pkg::FIFO_PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + rao_pkg::FIFO_PTR_W'(1);
      end
      count <= count + push_cnt - rao_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

FILE: design/router_advert_option_parser_core.sv
// Top level: byte-serial ICMPv6 router advertisement option parser.
//
//  channel  dir  tdata / tuser / tlast
//  s_axis   in   tdata[7:0] msg_byte, [19:8] msg_length; tlast last_byte
//  m_axis   out  tdata: status, prefix_upper, prefix_lower, prefix_bits,
//                prefix_flags, valid_lifetime, preferred_lifetime,
//                record_count; tuser kind; tlast last
//
// One byte per cycle while s_axis_tready is high; parse state updates in
// the cycle the beat is taken. A beat yields zero, one or two results into a
// four-entry output queue; s_axis_tready is high while it has room for two
// results. Results pass through the queue to m_axis; rst is synchronous.
module router_advert_option_parser_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // msg_byte, msg_length, zero pad
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [223:0] m_axis_tdata,   // status, prefix_upper, prefix_lower,
                                       // prefix_bits, prefix_flags,
                                       // valid_lifetime, preferred_lifetime,
                                       // record_count, zero pad
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast    // last
);

  logic [7:0]  b;
  logic [11:0] len;
  logic        fin;
  logic        accept;

  // control state
  logic [11:0]          byte_position, byte_position_next;
  logic [10:0]          option_bytes_left, option_bytes_left_next;
  logic [10:0]          option_offset, option_offset_next;
  logic [7:0]           option_kind, option_kind_next;
  rao_pkg::rao_status_t error_code, error_code_next;
  logic [6:0]           found_count, found_count_next;
  logic                 skip_rest, skip_rest_next;

  // prefix option captures
  logic [63:0] prefix_hi, prefix_hi_next;
  logic [63:0] prefix_lo, prefix_lo_next;
  logic [31:0] valid_cap, valid_cap_next;
  logic [31:0] pref_cap, pref_cap_next;
  logic [7:0]  bits_cap, bits_cap_next;
  logic [7:0]  flags_cap, flags_cap_next;

  logic [11:0] remaining;
  logic [10:0] olen;
  logic [12:0] got;
  logic        rec_push;
  rao_pkg::rao_status_t end_status;

  rao_pkg::rao_result_t rec_entry;
  rao_pkg::rao_result_t end_entry;
  rao_pkg::rao_result_t entry_first;
  rao_pkg::rao_push_t   push;
  rao_pkg::rao_result_t out_entry;
  logic                 room_for_two;

  assign b      = s_axis_tdata[7:0];
  assign len    = s_axis_tdata[19:8];
  assign fin    = s_axis_tlast;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign remaining = len - byte_position;
  assign olen      = {b, 3'b000};
  assign got       = {1'b0, byte_position} + 13'd1;

  always_comb begin
    byte_position_next     = (byte_position == rao_pkg::POS_MAX) ?
                             byte_position : byte_position + 12'd1;
    option_bytes_left_next = option_bytes_left;
    option_offset_next     = option_offset;
    option_kind_next       = option_kind;
    error_code_next        = error_code;
    found_count_next       = found_count;
    skip_rest_next         = skip_rest;
    prefix_hi_next         = prefix_hi;
    prefix_lo_next         = prefix_lo;
    valid_cap_next         = valid_cap;
    pref_cap_next          = pref_cap;
    bits_cap_next          = bits_cap;
    flags_cap_next         = flags_cap;
    rec_push               = 1'b0;
    end_status             = rao_pkg::ST_OK;

    if (!skip_rest_next && byte_position == '0 && len < rao_pkg::HDR_BYTES) begin
      error_code_next = rao_pkg::ST_TOO_SHORT;
      skip_rest_next  = 1'b1;
    end

    if (!skip_rest_next && byte_position < len) begin
      if (byte_position < rao_pkg::HDR_BYTES) begin
        if (byte_position == rao_pkg::MANAGED_POS && b[rao_pkg::MANAGED_BIT]) begin
          error_code_next = rao_pkg::ST_MANAGED;
          skip_rest_next  = 1'b1;
        end
      end else if (option_offset == 11'd0) begin
        if (remaining < rao_pkg::OPT_UNIT) begin
          skip_rest_next = 1'b1;
        end else begin
          option_kind_next   = b;
          option_offset_next = 11'd1;
        end
      end else if (option_offset == 11'd1) begin
        if ({2'b00, olen} > ({1'b0, remaining} + 13'd1)) begin
          error_code_next = rao_pkg::ST_OVERRUN;
          skip_rest_next  = 1'b1;
        end else if (option_kind == rao_pkg::PREFIX_OPT_TYPE &&
                     olen != rao_pkg::PREFIX_OPT_BYTES) begin
          error_code_next = rao_pkg::ST_BAD_PREFIX_LEN;
          skip_rest_next  = 1'b1;
        end else if (olen == 11'd0) begin
          error_code_next = rao_pkg::ST_ZERO_LEN;
          skip_rest_next  = 1'b1;
        end else begin
          option_bytes_left_next = olen - 11'd2;
          option_offset_next     = 11'd2;
        end
      end else begin
        if (option_kind == rao_pkg::PREFIX_OPT_TYPE) begin
          if (option_offset == 11'd2) begin
            bits_cap_next = b;
          end else if (option_offset == 11'd3) begin
            flags_cap_next = b;
          end else if (option_offset inside {[11'd4:11'd11]}) begin
            if (option_offset[3]) begin
              pref_cap_next = {pref_cap[23:0], b};
            end else begin
              valid_cap_next = {valid_cap[23:0], b};
            end
          end else if (option_offset inside {[11'd16:11'd31]}) begin
            if (option_offset[3]) begin
              prefix_lo_next = {prefix_lo[55:0], b};
            end else begin
              prefix_hi_next = {prefix_hi[55:0], b};
            end
          end
        end
        option_offset_next = option_offset + 11'd1;
        if (option_bytes_left != 11'd0) begin
          option_bytes_left_next = option_bytes_left - 11'd1;
        end
        if (option_bytes_left_next == 11'd0) begin
          if (option_kind == rao_pkg::PREFIX_OPT_TYPE) begin
            rec_push = 1'b1;
            if (found_count < rao_pkg::COUNT_MAX) begin
              found_count_next = found_count + 7'd1;
            end
          end
          option_offset_next = 11'd0;
        end
      end
    end

    end_status = error_code_next;
    if (error_code_next == rao_pkg::ST_OK && !skip_rest_next && got < {1'b0, len}) begin
      if (got < {1'b0, rao_pkg::HDR_BYTES}) begin
        end_status = rao_pkg::ST_TOO_SHORT;
      end else if (option_offset_next != 11'd0 ||
                   ({1'b0, len} - got) >= {1'b0, rao_pkg::OPT_UNIT}) begin
        end_status = rao_pkg::ST_OVERRUN;
      end
    end
  end

  always_comb begin
    rec_entry                    = '0;
    rec_entry.kind               = rao_pkg::KIND_RECORD;
    rec_entry.status             = rao_pkg::ST_OK;
    rec_entry.prefix_upper       = prefix_hi_next;
    rec_entry.prefix_lower       = prefix_lo_next;
    rec_entry.prefix_bits        = bits_cap_next;
    rec_entry.prefix_flags       = flags_cap_next;
    rec_entry.valid_lifetime     = valid_cap_next;
    rec_entry.preferred_lifetime = pref_cap_next;

    end_entry              = '0;
    end_entry.kind         = rao_pkg::KIND_END;
    end_entry.status       = end_status;
    end_entry.record_count = found_count_next;
    end_entry.last         = 1'b1;

    entry_first = rec_push ? rec_entry : end_entry;
    push.first  = accept && (rec_push || fin);
    push.second = accept && rec_push && fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      option_bytes_left <= '0;
      option_offset     <= '0;
      option_kind       <= '0;
      error_code        <= rao_pkg::ST_OK;
      found_count       <= '0;
      skip_rest         <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        byte_position     <= '0;
        option_bytes_left <= '0;
        option_offset     <= '0;
        option_kind       <= '0;
        error_code        <= rao_pkg::ST_OK;
        found_count       <= '0;
        skip_rest         <= 1'b0;
      end else begin
        byte_position     <= byte_position_next;
        option_bytes_left <= option_bytes_left_next;
        option_offset     <= option_offset_next;
        option_kind       <= option_kind_next;
        error_code        <= error_code_next;
        found_count       <= found_count_next;
        skip_rest         <= skip_rest_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix_hi <= prefix_hi_next;
      prefix_lo <= prefix_lo_next;
      valid_cap <= valid_cap_next;
      pref_cap  <= pref_cap_next;
      bits_cap  <= bits_cap_next;
      flags_cap <= flags_cap_next;
    end
  end

  rao_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .entry_first  (entry_first),
    .entry_second (end_entry),
    .room_for_two (room_for_two),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_entry    (out_entry)
  );

  assign s_axis_tready = room_for_two;

  assign m_axis_tdata = {6'b000000,
                         out_entry.record_count,
                         out_entry.preferred_lifetime,
                         out_entry.valid_lifetime,
                         out_entry.prefix_flags,
                         out_entry.prefix_bits,
                         out_entry.prefix_lower,
                         out_entry.prefix_upper,
                         out_entry.status};
  assign m_axis_tuser = out_entry.kind;
  assign m_axis_tlast = out_entry.last;

endmodule
